/* hw/rtl/gcev_pkg.sv */
// Shared constants, codes and types of the gamepad change event generator.
package gcev_pkg;

    localparam int NUM_BUTTONS = 16;
    localparam int NUM_TOUCHES = 2;

    // Widths of the snapshot as it arrives on the input stream.
    localparam int BTN_IN_W   = 16;
    localparam int TRG_W      = 16;
    localparam int STICK_W    = 64;
    localparam int TID_W      = 8;
    localparam int TPOS_W     = 16;
    localparam int IDENT_W    = 7;
    localparam int SEQ_W      = 16;
    localparam int CODE_W     = 5;
    localparam int VAL_W      = 8;

    localparam int S_DATA_W   = 184;
    localparam int M_DATA_W   = 136;

    // One pending bit per button, one each for L2 and R2, one per touch slot.
    localparam int EV_W       = NUM_BUTTONS + 2 + NUM_TOUCHES;
    localparam int EV_IDX_W   = $clog2(EV_W);
    localparam int BTN_IDX_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int TS_W       = (NUM_TOUCHES > 1) ? $clog2(NUM_TOUCHES) : 1;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [VAL_W-1:0] BTN_PRESSED  = 8'hFF;
    localparam logic [VAL_W-1:0] BTN_RELEASED = 8'h00;

    typedef enum logic {
        OP_SNAPSHOT = 1'b0,
        OP_TICK     = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_STATE  = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_TOUCH  = 2'd2
    } kind_t;

    typedef struct packed {
        logic               down;
        logic [IDENT_W-1:0] ident;
        logic [TPOS_W-1:0]  px;
        logic [TPOS_W-1:0]  py;
    } touch_ev_t;

    // Everything the back end needs to replay one request's results.
    typedef struct packed {
        logic                                state_pend;
        logic [STICK_W-1:0]                  axes;
        logic [NUM_BUTTONS-1:0]              btn_chg;
        logic [NUM_BUTTONS-1:0]              btn_now;
        logic                                l2_chg;
        logic                                r2_chg;
        logic [VAL_W-1:0]                    l2_val;
        logic [VAL_W-1:0]                    r2_val;
        logic [NUM_TOUCHES-1:0]              touch_chg;
        touch_ev_t [NUM_TOUCHES-1:0]         touch;
    } job_t;

endpackage

/* hw/rtl/gamepad_change_event_generator_top.sv */
// Top level of the gamepad change event generator.
//
// Input stream (s_*): one request is a controller snapshot or a timeout tick
// (s_tuser). A tick yields one state packet with the stored stick axes. A
// snapshot yields a state packet if sticks or motion changed, then one event
// per changed button, L2, R2 and touch slot; an unchanged snapshot yields
// nothing. Output stream (m_*): each request's results in order, tlast on the
// final one.
// Timing: the front end diffs a request in the cycle it is taken and queues
// the job (two deep). The back end loads a job and then emits one result per
// cycle while the receiver takes them, taking no new job until its last result
// is emitted; the first result passes through the queue, the back end's job
// registers and the output register. s_tready drops only while the job queue is full.
// Reset clears the stored snapshot (touch slots idle), both sequence counters
// and the queue. When the receiver stalls, the result stays in the output
// register and the back end waits; requests keep being taken until the queue
// fills.
module gamepad_change_event_generator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // buttons, triggers, sticks, motion_changed, touch0_id, touch0_x, touch0_y,
    // touch1_id, touch1_x, touch1_y, zero pad
    input  logic [gcev_pkg::S_DATA_W-1:0] s_tdata,
    // opcode
    input  gcev_pkg::opcode_t             s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // seq, event_code, event_value, touch_down, touch_ident, touch_px, touch_py,
    // stick_axes, zero pad
    output logic [gcev_pkg::M_DATA_W-1:0] m_tdata,
    // kind
    output gcev_pkg::kind_t               m_tuser,
    output logic                          m_tlast
);
    import gcev_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    gcev_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    gcev_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    gcev_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* hw/rtl/gcev_front.sv */
// Front end: takes snapshots and ticks, diffs against the stored snapshot, queues jobs.
module gcev_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gcev_pkg::S_DATA_W-1:0] s_tdata,
    input  gcev_pkg::opcode_t             s_tuser,
    output logic                          job_valid,
    input  logic                          job_ready,
    output gcev_pkg::job_t                job
);
    import gcev_pkg::*;

    logic [NUM_BUTTONS-1:0]             prev_btn_reg;
    logic [TRG_W-1:0]                   prev_trg_reg;
    logic [STICK_W-1:0]                 prev_stk_reg;
    logic [NUM_TOUCHES-1:0][TID_W-1:0]  prev_id_reg;
    logic [NUM_TOUCHES-1:0][TPOS_W-1:0] prev_x_reg;
    logic [NUM_TOUCHES-1:0][TPOS_W-1:0] prev_y_reg;

    logic [NUM_BUTTONS-1:0]             btn_cur;
    logic [TRG_W-1:0]                   trg_in;
    logic [STICK_W-1:0]                 stk_in;
    logic                               motion;
    logic [NUM_TOUCHES-1:0][TID_W-1:0]  cur_id;
    logic [NUM_TOUCHES-1:0][TPOS_W-1:0] cur_x;
    logic [NUM_TOUCHES-1:0][TPOS_W-1:0] cur_y;
    logic                               is_tick;
    logic                               any_result;
    logic                               accept;

    always_comb
    begin
        trg_in  = s_tdata[31:16];
        stk_in  = s_tdata[95:32];
        motion  = s_tdata[96];
        is_tick = (s_tuser == OP_TICK);

        // buttons past the input bitmap never press
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            btn_cur[i] = 1'b0;
            if (i < BTN_IN_W)
                btn_cur[i] = s_tdata[i];
        end

        // slots past the two on the wire never touch
        for (int i = 0; i < NUM_TOUCHES; i++)
        begin
            cur_id[i] = '1;
            cur_x[i]  = '0;
            cur_y[i]  = '0;
            if (i == 0)
            begin
                cur_id[i] = s_tdata[104:97];
                cur_x[i]  = s_tdata[120:105];
                cur_y[i]  = s_tdata[136:121];
            end
            else if (i == 1)
            begin
                cur_id[i] = s_tdata[144:137];
                cur_x[i]  = s_tdata[160:145];
                cur_y[i]  = s_tdata[176:161];
            end
        end

        job = '0;
        if (is_tick)
        begin
            job.state_pend = 1'b1;
            job.axes       = prev_stk_reg;
        end
        else
        begin
            job.state_pend = (stk_in != prev_stk_reg) || motion;
            job.axes       = stk_in;
            job.btn_chg    = btn_cur ^ prev_btn_reg;
            job.btn_now    = btn_cur;
            job.l2_chg     = (trg_in[15:8] != prev_trg_reg[15:8]);
            job.r2_chg     = (trg_in[7:0] != prev_trg_reg[7:0]);
            job.l2_val     = trg_in[15:8];
            job.r2_val     = trg_in[7:0];
            for (int i = 0; i < NUM_TOUCHES; i++)
            begin
                // id change on an active slot reports only the release
                if ((prev_id_reg[i] != cur_id[i]) && !prev_id_reg[i][TID_W-1])
                begin
                    job.touch_chg[i]     = 1'b1;
                    job.touch[i].down    = 1'b0;
                    job.touch[i].ident   = prev_id_reg[i][IDENT_W-1:0];
                    job.touch[i].px      = prev_x_reg[i];
                    job.touch[i].py      = prev_y_reg[i];
                end
                else if (!cur_id[i][TID_W-1] && ((prev_id_reg[i] != cur_id[i]) ||
                         (prev_x_reg[i] != cur_x[i]) || (prev_y_reg[i] != cur_y[i])))
                begin
                    job.touch_chg[i]     = 1'b1;
                    job.touch[i].down    = 1'b1;
                    job.touch[i].ident   = cur_id[i][IDENT_W-1:0];
                    job.touch[i].px      = cur_x[i];
                    job.touch[i].py      = cur_y[i];
                end
            end
        end

        any_result = job.state_pend || (|job.btn_chg) || job.l2_chg || job.r2_chg ||
                     (|job.touch_chg);
    end

    assign s_tready  = job_ready;
    assign accept    = s_tvalid && s_tready;
    // a snapshot that changes nothing is taken and dropped
    assign job_valid = s_tvalid && any_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_btn_reg <= '0;
            prev_trg_reg <= '0;
            prev_stk_reg <= '0;
            prev_id_reg  <= '1;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
        end
        else if (accept && !is_tick)
        begin
            prev_btn_reg <= btn_cur;
            prev_trg_reg <= trg_in;
            prev_stk_reg <= stk_in;
            prev_id_reg  <= cur_id;
            prev_x_reg   <= cur_x;
            prev_y_reg   <= cur_y;
        end
    end

endmodule

/* hw/rtl/gcev_fifo.sv */
// Short job queue between the front and back ends.
module gcev_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  gcev_pkg::job_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output gcev_pkg::job_t pop_data
);
    import gcev_pkg::*;

    job_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* hw/rtl/gcev_back.sv */
// Back end: walks one job's pending results into the output register, one per cycle unless stalled.
module gcev_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  gcev_pkg::job_t                job,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gcev_pkg::M_DATA_W-1:0] m_tdata,
    output gcev_pkg::kind_t               m_tuser,
    output logic                          m_tlast
);
    import gcev_pkg::*;

    function automatic logic [EV_IDX_W-1:0] first_set(input logic [EV_W-1:0] m);
        logic [EV_IDX_W-1:0] idx;
        idx = '0;
        for (int i = EV_W - 1; i >= 0; i--)
        begin
            if (m[i])
                idx = EV_IDX_W'(i);
        end
        return idx;
    endfunction

    logic                busy_reg;
    job_t                cur_reg;
    logic                state_pend_reg;
    logic [EV_W-1:0]     mask_reg;
    logic [SEQ_W-1:0]    state_cnt_reg;
    logic [SEQ_W-1:0]    hist_cnt_reg;

    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic                out_last_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic                emit;
    logic [EV_IDX_W-1:0] idx;
    logic [EV_W-1:0]     idx_bit;
    logic [EV_W-1:0]     mask_left;
    logic [EV_IDX_W-1:0] slot_off;
    logic [TS_W-1:0]     slot;
    logic                is_last;
    kind_t               kind_next;
    logic [SEQ_W-1:0]    seq_next;
    logic [CODE_W-1:0]   code_next;
    logic [VAL_W-1:0]    val_next;
    touch_ev_t           tev_next;
    logic [STICK_W-1:0]  axes_next;

    assign job_ready = !busy_reg;
    assign emit      = busy_reg && (!out_valid_reg || m_tready);

    always_comb
    begin
        idx       = first_set(mask_reg);
        idx_bit   = EV_W'(1) << idx;
        mask_left = mask_reg & ~idx_bit;
        slot_off  = idx - EV_IDX_W'(NUM_BUTTONS + 2);
        slot      = slot_off[TS_W-1:0];
        is_last   = state_pend_reg ? (mask_reg == '0) : (mask_left == '0);

        kind_next = KIND_STATE;
        code_next = '0;
        val_next  = '0;
        tev_next  = '0;
        axes_next = '0;
        if (state_pend_reg)
        begin
            axes_next = cur_reg.axes;
        end
        else if (idx < EV_IDX_W'(NUM_BUTTONS))
        begin
            kind_next = KIND_BUTTON;
            code_next = CODE_W'(idx);
            val_next  = cur_reg.btn_now[idx[BTN_IDX_W-1:0]] ? BTN_PRESSED : BTN_RELEASED;
        end
        else if (idx == EV_IDX_W'(NUM_BUTTONS))
        begin
            kind_next = KIND_BUTTON;
            code_next = CODE_W'(NUM_BUTTONS);
            val_next  = cur_reg.l2_val;
        end
        else if (idx == EV_IDX_W'(NUM_BUTTONS + 1))
        begin
            kind_next = KIND_BUTTON;
            code_next = CODE_W'(NUM_BUTTONS + 1);
            val_next  = cur_reg.r2_val;
        end
        else
        begin
            kind_next = KIND_TOUCH;
            tev_next  = cur_reg.touch[slot];
        end
        seq_next = (kind_next == KIND_STATE) ? state_cnt_reg : hist_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            state_pend_reg <= 1'b0;
            mask_reg       <= '0;
            state_cnt_reg  <= '0;
            hist_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_STATE;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (!busy_reg && job_valid)
            begin
                busy_reg       <= 1'b1;
                state_pend_reg <= job.state_pend;
                mask_reg       <= {job.touch_chg, job.r2_chg, job.l2_chg, job.btn_chg};
            end
            else if (emit)
            begin
                if (state_pend_reg)
                begin
                    state_pend_reg <= 1'b0;
                    state_cnt_reg  <= state_cnt_reg + 1'b1;
                end
                else
                begin
                    mask_reg     <= mask_left;
                    hist_cnt_reg <= hist_cnt_reg + 1'b1;
                end
                if (is_last)
                    busy_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= kind_next;
                out_last_reg  <= is_last;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && job_valid)
            cur_reg <= job;
        if (emit)
            out_data_reg <= {3'b000, axes_next, tev_next.py, tev_next.px, tev_next.ident,
                             tev_next.down, val_next, code_next, seq_next};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
